/* rtl/core/frg_pkg.sv */
package frg_pkg;

  // Operand width of the block
  localparam int DATA_BITS = 31;
  // Bit counter width for the serial divider (steps 0 .. DATA_BITS-1; ends at DATA_BITS)
  localparam int CNT_BITS  = $clog2(DATA_BITS);

  typedef logic [DATA_BITS-1:0] data_t;

  // Input transaction payload
  typedef struct packed {
    data_t numer_in;
    data_t denom_in;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    data_t numer_out;
    data_t denom_out;
    data_t common_divisor;
    logic  zero_error;
  } out_t;

  // Sequencer to divider
  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  // Divider to sequencer
  typedef struct packed {
    logic  busy;
    logic  done;
    data_t quot;
    data_t rem;
  } div_rsp_t;

endpackage

/* rtl/core/frg_div.sv */
module frg_div (
  input  logic                clk,
  input  logic                rst_n,
  input  frg_pkg::div_req_t   req,
  output frg_pkg::div_rsp_t   rsp
);

  localparam logic [frg_pkg::CNT_BITS-1:0] CNT_LAST =
    frg_pkg::CNT_BITS'(frg_pkg::DATA_BITS - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [frg_pkg::CNT_BITS-1:0] cnt_r, cnt_nxt;
  frg_pkg::data_t               quo_r, quo_nxt;
  frg_pkg::data_t               rem_r, rem_nxt;
  frg_pkg::data_t               dvs_r, dvs_nxt;

  logic [frg_pkg::DATA_BITS:0]  trial;
  logic [frg_pkg::DATA_BITS:0]  diff;
  logic                         fits;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign trial = {rem_r, quo_r[frg_pkg::DATA_BITS-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (busy_r) begin
      quo_nxt = {quo_r[frg_pkg::DATA_BITS-2:0], fits};
      rem_nxt = fits ? diff[frg_pkg::DATA_BITS-1:0] : trial[frg_pkg::DATA_BITS-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

`ifndef ASSERT_OFF
  // Sequencer never launches into a running division
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // Final remainder is below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder out of range");

  // Done pulses once, right after the last step
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");
`endif

endmodule

/* rtl/core/fraction_reduce_gcd.sv */
// Channel   Ports                        Transaction
// -------   --------------------------   ------------------------------------
// input     start, busy, in_data         accepted when start && !busy
// result    out_valid, out_data          valid for one cycle, always taken
//
// One shared bit-serial restoring divider does every division. Each Euclid
// remainder step issues a division from S_LOOP and waits in S_REM for its
// done; the two reducing divisions then run in S_DIVN and S_DIVD. Two zero
// operands skip the loop and give the error result straight from the idle
// state. busy is high for the whole run. rst_n is synchronous, active low,
// and clears the sequencer and divider control.
// The receiver cannot stall; out_data holds its value until the next result.
module fraction_reduce_gcd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  frg_pkg::in_t  in_data,
  output logic          out_valid,
  output frg_pkg::out_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOP = 3'd1;
  localparam logic [2:0] S_REM  = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVD = 3'd4;

  logic [2:0]          state_r, state_nxt;
  frg_pkg::data_t      num_r, num_nxt;
  frg_pkg::data_t      den_r, den_nxt;
  frg_pkg::data_t      big_r, big_nxt;
  frg_pkg::data_t      small_r, small_nxt;
  frg_pkg::data_t      qn_r, qn_nxt;
  logic                out_valid_r, out_valid_nxt;
  frg_pkg::out_t       out_r, out_nxt;
  frg_pkg::div_req_t   div_req;
  frg_pkg::div_rsp_t   div_rsp;
  logic                accept;

  assign accept = start && (state_r == S_IDLE);

  frg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer: Euclid remainder loop, then the two reducing divisions
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    big_nxt       = big_r;
    small_nxt     = small_r;
    qn_nxt        = qn_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          num_nxt = in_data.numer_in;
          den_nxt = in_data.denom_in;
          if ((in_data.numer_in == '0) && (in_data.denom_in == '0)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.zero_error = 1'b1;
          end else begin
            if (in_data.denom_in > in_data.numer_in) begin
              big_nxt   = in_data.denom_in;
              small_nxt = in_data.numer_in;
            end else begin
              big_nxt   = in_data.numer_in;
              small_nxt = in_data.denom_in;
            end
            state_nxt = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        div_req.start = 1'b1;
        if (small_r == '0) begin
          div_req.dividend = num_r;
          div_req.divisor  = big_r;
          state_nxt        = S_DIVN;
        end else begin
          div_req.dividend = big_r;
          div_req.divisor  = small_r;
          state_nxt        = S_REM;
        end
      end
      S_REM: begin
        if (div_rsp.done) begin
          big_nxt   = small_r;
          small_nxt = div_rsp.rem;
          state_nxt = S_LOOP;
        end
      end
      S_DIVN: begin
        if (div_rsp.done) begin
          qn_nxt           = div_rsp.quot;
          div_req.start    = 1'b1;
          div_req.dividend = den_r;
          div_req.divisor  = big_r;
          state_nxt        = S_DIVD;
        end
      end
      S_DIVD: begin
        if (div_rsp.done) begin
          out_valid_nxt          = 1'b1;
          out_nxt.numer_out      = qn_r;
          out_nxt.denom_out      = div_rsp.quot;
          out_nxt.common_divisor = big_r;
          out_nxt.zero_error     = 1'b0;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operands and result
  always_ff @(posedge clk) begin
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    big_r   <= big_nxt;
    small_r <= small_nxt;
    qn_r    <= qn_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // A normal result always carries a nonzero divisor
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.zero_error |-> out_data.common_divisor != '0)
    else $error("zero divisor on a normal result");

  // Error result carries all-zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_error |->
      (out_data.numer_out == '0) && (out_data.denom_out == '0) &&
      (out_data.common_divisor == '0))
    else $error("error result with nonzero fields");

  // A result comes only from an accepted item or the last division
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept) || $past(state_r == S_DIVD))
    else $error("result strobe without a source");

  // Neither the Euclid loop nor the reducing divisions ever divide by zero
  a_no_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.divisor != '0)
    else $error("division by zero launched");
`endif

endmodule
